[rtl/core/rmd_pkg.sv]
// Package for the running mean deviation core: field widths, payload types
// and the sequencer state type. No dependencies.
package rmd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RESULT_W = 17;
    localparam int STEP_W   = $clog2(SAMPLE_W);

    typedef logic [SAMPLE_W-1:0]        sample_t;
    typedef logic signed [RESULT_W-1:0] result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DONE
    } state_t;

endpackage

[rtl/core/rmd_stream_if.sv]
// Valid/ready channel interfaces for samples and results.
// Depends on rmd_pkg for the payload types.
interface rmd_sample_if;
    logic             valid;
    logic             ready;
    rmd_pkg::sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rmd_result_if;
    logic             valid;
    logic             ready;
    rmd_pkg::result_t mean_minus_sample;

    modport source (output valid, output mean_minus_sample, input ready);
    modport sink   (input valid, input mean_minus_sample, output ready);
endinterface

[rtl/core/rmd_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module rmd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 15
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/core/running_mean_deviation_core.sv]
// Top level of the running mean deviation core: window ring, running sum
// and a bit-serial divider. Depends on rmd_pkg, rmd_stream_if and rmd_ram.
//
// Usage. Samples arrive on the "samples" channel and one result per sample
// leaves on the "results" channel; a transfer happens at a rising clock edge
// with valid and ready both high. For each sample the core replaces the
// oldest of the last WINDOW samples, updates a 16-bit running sum that wraps
// modulo 2^16, and returns the truncated mean (sum divided by the number of
// samples held, up to WINDOW) minus the new sample as a 17-bit signed value.
//
// Timing. The core works on one sample at a time. After the sample transfer,
// the UPDATE state takes the oldest entry from the window RAM and updates
// the sum, then a restoring divider produces one quotient bit per cycle over
// its 16 steps, and the DONE state forms the difference into the output
// register once that register is free. Only then does the core return to
// idle and take the next sample; the 16 steps of the serial divider take
// most of the time per sample.
//
// Reset clears the sum, the fill count and the write slot. The window RAM is
// not cleared; entries not yet written are read as zero by means of the fill
// count. When the receiver stalls, the result waits in the output register
// while the next sample is taken and processed; a second result waits in the
// final state until the register is free.
module running_mean_deviation_core #(
    parameter int WINDOW = 15
) (
    input  logic         clk,
    input  logic         rst_n,
    rmd_sample_if.sink   samples,
    rmd_result_if.source results
);

    localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);

    localparam logic [CW-1:0] WIN_FULL  = CW'(WINDOW);
    localparam logic [SW-1:0] LAST_SLOT = SW'(WINDOW - 1);
    localparam logic [rmd_pkg::STEP_W-1:0] LAST_STEP =
        rmd_pkg::STEP_W'(rmd_pkg::SAMPLE_W - 1);

    rmd_pkg::state_t          state_reg, state_next;
    logic [SW-1:0]            slot_reg, slot_next;
    logic [CW-1:0]            fill_reg, fill_next;
    rmd_pkg::sample_t         sum_reg, sum_next;
    rmd_pkg::sample_t         samp_reg, samp_next;
    rmd_pkg::sample_t         quo_reg, quo_next;
    logic [CW:0]              rem_reg, rem_next;
    logic [rmd_pkg::STEP_W-1:0] step_reg, step_next;
    logic                     out_valid_reg, out_valid_next;
    rmd_pkg::result_t         out_data_reg, out_data_next;

    rmd_pkg::sample_t         ram_rd_data;
    rmd_pkg::sample_t         old_value;
    logic                     ram_wr_en;
    logic [CW:0]              shifted;
    logic [CW:0]              divisor;
    logic                     quo_bit;
    logic                     out_free;

    rmd_ram #(
        .WIDTH (rmd_pkg::SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_window (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_reg),
        .wr_data (samp_reg),
        .rd_addr (slot_reg),
        .rd_data (ram_rd_data)
    );

    // Until the window has filled once, the slot being replaced was never
    // written and counts as zero.
    assign old_value = (fill_reg == WIN_FULL) ? ram_rd_data : '0;

    // One restoring division step: bring down the next dividend bit and
    // subtract the fill count when it fits.
    assign shifted = {rem_reg[CW-1:0], quo_reg[rmd_pkg::SAMPLE_W-1]};
    assign divisor = {1'b0, fill_reg};
    assign quo_bit = (shifted >= divisor);

    assign out_free = !out_valid_reg || results.ready;

    assign samples.ready             = (state_reg == rmd_pkg::ST_IDLE);
    assign results.valid             = out_valid_reg;
    assign results.mean_minus_sample = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rmd_pkg::ST_IDLE;
            slot_reg      <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg     <= samp_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        samp_next      = samp_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !results.ready;
        ram_wr_en      = 1'b0;

        case (state_reg)
            rmd_pkg::ST_IDLE:
            begin
                if (samples.valid)
                begin
                    samp_next  = samples.sample;
                    state_next = rmd_pkg::ST_UPDATE;
                end
            end

            rmd_pkg::ST_UPDATE:
            begin
                // The RAM has returned the oldest entry; swap it for the
                // new sample and advance the ring.
                ram_wr_en = 1'b1;
                sum_next  = sum_reg - old_value + samp_reg;
                quo_next  = sum_reg - old_value + samp_reg;
                rem_next  = '0;
                step_next = '0;
                slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                if (fill_reg != WIN_FULL)
                begin
                    fill_next = fill_reg + 1'b1;
                end
                state_next = rmd_pkg::ST_DIVIDE;
            end

            rmd_pkg::ST_DIVIDE:
            begin
                rem_next  = quo_bit ? (shifted - divisor) : shifted;
                quo_next  = {quo_reg[rmd_pkg::SAMPLE_W-2:0], quo_bit};
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = rmd_pkg::ST_DONE;
                end
            end

            rmd_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_next  = $signed({1'b0, quo_reg}) - $signed({1'b0, samp_reg});
                    out_valid_next = 1'b1;
                    state_next     = rmd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rmd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[test/running_mean_deviation_core_tb.sv]
// Testbench for running_mean_deviation_core: a directed table, then random samples,
// all but the typed rows checked against a local model of window, sum and divider.
// Depends on rmd_pkg, rmd_stream_if and the core itself.
`timescale 1ns / 100ps

module running_mean_deviation_core_tb;

    localparam int WINDOW       = 15;
    localparam int RANDOM_ITEMS = 1000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int ROWS         = 21;

    logic clk;
    logic rst_n;

    rmd_sample_if sample_ch ();
    rmd_result_if result_ch ();

    running_mean_deviation_core #(
        .WINDOW(WINDOW)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .samples(sample_ch),
        .results(result_ch)
    );

    // One row of the directed table. Where typed is set, val is the result
    // that can be read straight off the window contents; other rows take the
    // result from the local model.
    typedef struct packed {
        rmd_pkg::sample_t s;
        logic             typed;
        rmd_pkg::result_t val;
    } row_t;

    row_t    directed_rows [0:ROWS-1];

    // Local copy of the window state, advanced at every sample transfer.
    rmd_pkg::sample_t ring_copy [0:WINDOW-1];
    int unsigned      slot_copy;
    logic [15:0]      sum_copy;
    int unsigned      fill_copy;

    // Results still owed by the core, oldest first.
    rmd_pkg::result_t deviation_q [$];

    // Side information that travels with the sample currently offered.
    logic             row_typed;
    rmd_pkg::result_t row_exp;

    int mismatch_count;
    int cycle_count;

    // Clock: 8 ns period.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: a run that reaches the cycle limit ends as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic clear_window_copy();
        for (int k = 0; k < WINDOW; k++)
            ring_copy[k] = '0;
        slot_copy = 0;
        sum_copy  = '0;
        fill_copy = 0;
    endtask

    // Advances the window copy by one sample and returns the deviation of
    // the truncated mean from that sample. The sum wraps modulo 2^16 just
    // as the core's register does, so a window of large samples gives a
    // small mean on purpose.
    function automatic rmd_pkg::result_t next_deviation(input rmd_pkg::sample_t s);
        int unsigned idx;
        logic [15:0] mean;
        logic [16:0] diff;
        idx = (slot_copy < WINDOW) ? slot_copy : 0;
        sum_copy = sum_copy - ring_copy[idx];
        ring_copy[idx] = s;
        sum_copy = sum_copy + s;
        idx = idx + 1;
        if (idx >= WINDOW)
            idx = 0;
        slot_copy = idx;
        if (fill_copy < WINDOW)
            fill_copy = fill_copy + 1;
        mean = (fill_copy != 0) ? 16'(sum_copy / fill_copy) : 16'd0;
        diff = {1'b0, mean} - {1'b0, s};
        return rmd_pkg::result_t'(diff);
    endfunction

    // Random samples lean toward the values that stress the wrapping sum
    // and the divider: near full scale, tiny, the two rails, single bits and single zeros.
    function automatic rmd_pkg::sample_t random_sample();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return rmd_pkg::sample_t'($urandom);
        else if (pick < 60)
            return rmd_pkg::sample_t'($urandom_range(16'hFF00, 16'hFFFF));
        else if (pick < 75)
            return rmd_pkg::sample_t'($urandom_range(0, 31));
        else if (pick < 85)
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        else if (pick < 93)
            return rmd_pkg::sample_t'(16'h0001 << $urandom_range(0, 15));
        else
            return ~rmd_pkg::sample_t'(16'h0001 << $urandom_range(0, 15));
    endfunction

    // Offers one sample from the falling edge on and returns at the rising
    // edge of its transfer. Valid stays high into the next call, so
    // back-to-back samples never see valid drop.
    task automatic send_sample(input rmd_pkg::sample_t s, input logic typed,
                               input rmd_pkg::result_t val);
        @(negedge clk);
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        row_typed        <= typed;
        row_exp          <= val;
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    // Holds the sample channel idle, with noise on the payload; n sets how long.
    task automatic idle_sender(input int n);
        repeat (n)
        begin
            @(negedge clk);
            sample_ch.valid  <= 1'b0;
            sample_ch.sample <= rmd_pkg::sample_t'($urandom);
        end
    endtask

    // Receiver. The stall pattern follows bits 10 and 9 of the cycle count: always ready,
    // a short regular stall, coin flips, and long stalls that let a second
    // result pile up behind the output register.
    initial
    begin
        logic [1:0] stall_mode;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall_mode = cycle_count[10:9];
            case (stall_mode)
                2'd0: result_ch.ready <= 1'b1;
                2'd1: result_ch.ready <= (cycle_count % 8) != 0;
                2'd2: result_ch.ready <= $urandom_range(0, 1);
                default: result_ch.ready <= (cycle_count % 64) < 6;
            endcase
        end
    end

    // Monitor. Every sample transfer queues its expected deviation and
    // every result transfer is checked against the oldest one queued.
    always @(posedge clk)
    begin
        rmd_pkg::result_t predicted;
        rmd_pkg::result_t wanted;
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                predicted = next_deviation(sample_ch.sample);
                deviation_q.push_back(row_typed ? row_exp : predicted);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (deviation_q.size() == 0)
                    report_mismatch($sformatf("result %0d with none expected",
                                              result_ch.mean_minus_sample));
                else
                begin
                    wanted = deviation_q.pop_front();
                    if (result_ch.mean_minus_sample !== wanted)
                        report_mismatch($sformatf("mean_minus_sample %0d, expected %0d",
                                                  result_ch.mean_minus_sample, wanted));
                end
            end
        end
    end

    // Stimulus and the end of the run.
    initial
    begin
        int burst_left;
        logic quiet;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        row_typed        = 1'b0;
        row_exp          = '0;
        mismatch_count   = 0;
        cycle_count      = 0;
        clear_window_copy();

        // The first sample after reset is its own mean, so it deviates by
        // zero. The second row halves a full-scale sum and subtracts zero.
        // The run of full-scale samples that follows fills the window,
        // wraps the sum several times and carries the write slot past its
        // last position; the rows after it overwrite the oldest entries.
        directed_rows = '{
            '{16'hFFFF, 1'b1, 17'sd0},
            '{16'h0000, 1'b1, 17'sd32767},
            '{16'h0001, 1'b0, 17'sd0},
            '{16'h8000, 1'b0, 17'sd0},
            '{16'h5555, 1'b0, 17'sd0},
            '{16'hAAAA, 1'b0, 17'sd0},
            '{16'h7FFF, 1'b0, 17'sd0},
            '{16'hFFFF, 1'b0, 17'sd0},
            '{16'hFFFF, 1'b0, 17'sd0},
            '{16'hFFFF, 1'b0, 17'sd0},
            '{16'hFFFF, 1'b0, 17'sd0},
            '{16'hFFFF, 1'b0, 17'sd0},
            '{16'hFFFF, 1'b0, 17'sd0},
            '{16'hFFFF, 1'b0, 17'sd0},
            '{16'hFFFF, 1'b0, 17'sd0},
            '{16'hFFFF, 1'b0, 17'sd0},
            '{16'h0000, 1'b0, 17'sd0},
            '{16'h0001, 1'b0, 17'sd0},
            '{16'hFFFF, 1'b0, 17'sd0},
            '{16'h1234, 1'b0, 17'sd0},
            '{16'h0000, 1'b0, 17'sd0}
        };

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < ROWS; r++)
        begin
            send_sample(directed_rows[r].s, directed_rows[r].typed, directed_rows[r].val);
            if ($urandom_range(0, 3) == 0)
                idle_sender($urandom_range(1, 20));
        end

        // Random part. The sender runs in bursts with gaps long enough to
        // land on every cycle of the divider; one stretch has no gaps at all.
        burst_left = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            quiet = (i >= 200) && (i < 300);
            if (i == RANDOM_ITEMS / 2)
            begin
                // Let the core run completely dry before going on.
                idle_sender(1);
                while (deviation_q.size() != 0)
                    @(negedge clk);
            end
            if (burst_left == 0)
            begin
                if (!quiet)
                    idle_sender($urandom_range(1, 45));
                burst_left = $urandom_range(1, 8);
            end
            send_sample(random_sample(), 1'b0, '0);
            burst_left--;
        end

        idle_sender(1);
        while (deviation_q.size() != 0)
            @(negedge clk);
        // With no result owed, wait on for strays.
        repeat (60) @(negedge clk);

        if (mismatch_count == 0 && deviation_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
